// ===== rtl/core/itoa_pkg.sv =====
package itoa_pkg;

	localparam int CHAR_W    = 7;
	localparam int BASE_W    = 5;
	localparam int DIGIT_W   = 4;
	// quotient bits resolved per cycle by the shared divide step
	localparam int STEP_BITS = 8;

	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [BASE_W-1:0]  base_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	localparam base_t BASE_MIN    = 5'd2;
	localparam base_t BASE_MAX    = 5'd16;
	localparam base_t BASE_SIGNED = 5'd10;

	localparam char_t CHAR_ZERO  = 7'h30;
	localparam char_t CHAR_ALPHA = 7'h61;
	localparam char_t CHAR_MINUS = 7'h2d;
	localparam char_t CHAR_NONE  = 7'h00;

	// lowercase hex digit, '0'-'9' then 'a'-'f'
	function automatic char_t digit_char(input digit_t d);
		char_t c;
		if (d < 4'd10) c = CHAR_ZERO + char_t'(d);
		else c = CHAR_ALPHA + char_t'(d - 4'd10);
		return c;
	endfunction

endpackage

// ===== rtl/core/itoa_if.sv =====
interface itoa_in_if #(parameter int VALUE_WIDTH = 32);
	import itoa_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;
	base_t                  base;
	logic                   signed_mode;

	modport source (output valid, value, base, signed_mode, input ready);
	modport sink   (input valid, value, base, signed_mode, output ready);
endinterface

interface itoa_out_if;
	import itoa_pkg::*;
	logic  valid;
	logic  ready;
	char_t character;
	logic  last;
	logic  empty_res;

	modport source (output valid, character, last, empty_res, input ready);
	modport sink   (input valid, character, last, empty_res, output ready);
endinterface

// ===== rtl/core/integer_to_ascii_radix.sv =====
// Integer to ASCII conversion in a selectable radix.
// in_ch carries value, base and signed_mode; out_ch carries one character
// per transfer, most significant digit first, with last on the final one.
// In signed mode with base ten a negative value gets a leading '-'.
// A base outside 2..16 gives a single transfer with empty_res and last set.
// One item at a time: in_ch.ready is high only while the sequencer idles.
// Each digit comes from the shared restoring-divide step (8 quotient
// bits a cycle) run over the whole quotient; the digits fill the digit
// store, with a minus sign after them when one is due, and then stream
// out from the top of the store at one character a cycle while the
// receiver takes them.
// The output register lets the next item be taken while the final
// character still waits. If the receiver stalls, streaming pauses and the
// character on out_ch holds until taken.
// Reset returns the sequencer to idle and drops any pending output;
// the digit store needs no clearing since each entry is written before use.
module integer_to_ascii_radix
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int STORE_DEPTH = 34
) (
	input  logic       clk,
	input  logic       arst_n,
	itoa_in_if.sink    in_ch,
	itoa_out_if.source out_ch
);

	localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PW     = CHUNKS * STEP_BITS;
	localparam int CKW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int CW     = $clog2(STORE_DEPTH + 1);
	localparam int IW     = $clog2(STORE_DEPTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_MINUS = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	logic [2:0]     state_q;
	logic [PW-1:0]  quot_q;
	digit_t         rem_q;
	base_t          base_q;
	logic           neg_q;
	logic [CKW-1:0] chunk_q;
	logic [CW-1:0]  cnt_q;

	logic           out_valid_q;
	char_t          out_char_q;
	logic           out_last_q;
	logic           out_empty_q;

	char_t          store_mem [STORE_DEPTH];

	logic                   in_xfer;
	logic                   out_free;
	logic                   base_bad;
	logic                   in_neg;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic [PW-1:0]          quot_next;
	digit_t                 rem_next;
	logic [STEP_BITS-1:0]   qbits;
	logic                   chunk_last;
	logic                   wr_en;
	char_t                  wr_char;
	logic [IW-1:0]          wr_idx;
	logic [CW-1:0]          cnt_dec;
	logic [IW-1:0]          rd_idx;
	logic                   emit_load;
	logic                   empty_load;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// input decode: radix check and signed magnitude
	assign base_bad = (in_ch.base < BASE_MIN) || (in_ch.base > BASE_MAX);
	assign in_neg   = in_ch.signed_mode && (in_ch.base == BASE_SIGNED)
	                  && in_ch.value[VALUE_WIDTH-1];
	assign in_mag   = in_neg ? (~in_ch.value + 1'b1) : in_ch.value;

	// shared divide step: STEP_BITS restoring iterations on a narrow remainder
	always_comb begin
		logic [BASE_W-1:0] t;
		digit_t            r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, quot_q[PW-1-i]};
			if (t >= base_q) begin
				t                    = t - base_q;
				qbits[STEP_BITS-1-i] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_next  = r;
		quot_next = (quot_q << STEP_BITS) | PW'(qbits);
	end

	assign chunk_last = (chunk_q == CKW'(CHUNKS - 1));

	// digit store write and read addressing
	assign wr_en   = (((state_q == ST_DIV) && chunk_last) || (state_q == ST_MINUS))
	                 && (cnt_q < CW'(STORE_DEPTH));
	assign wr_char = (state_q == ST_MINUS) ? CHAR_MINUS : digit_char(rem_next);
	assign wr_idx  = cnt_q[IW-1:0];
	assign cnt_dec = cnt_q - 1'b1;
	assign rd_idx  = cnt_dec[IW-1:0];

	assign emit_load  = (state_q == ST_EMIT) && out_free;
	assign empty_load = (state_q == ST_EMPTY) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quot_q  <= '0;
			rem_q   <= '0;
			base_q  <= '0;
			neg_q   <= 1'b0;
			chunk_q <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (base_bad) begin
							state_q <= ST_EMPTY;
						end else begin
							quot_q  <= PW'(in_mag);
							rem_q   <= '0;
							base_q  <= in_ch.base;
							neg_q   <= in_neg;
							chunk_q <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					quot_q  <= quot_next;
					rem_q   <= rem_next;
					chunk_q <= chunk_q + 1'b1;
					if (chunk_last) begin
						rem_q   <= '0;
						chunk_q <= '0;
						if (wr_en) cnt_q <= cnt_q + 1'b1;
						if (quot_next == '0) state_q <= neg_q ? ST_MINUS : ST_EMIT;
					end
				end
				ST_MINUS: begin
					if (wr_en) cnt_q <= cnt_q + 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_dec;
						if (cnt_q == CW'(1)) state_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digit store write port
	always_ff @(posedge clk) begin
		if (wr_en) store_mem[wr_idx] <= wr_char;
	end

	// registered read straight into the output character
	always_ff @(posedge clk) begin
		if (emit_load) out_char_q <= store_mem[rd_idx];
		else if (empty_load) out_char_q <= CHAR_NONE;
	end

	// output register flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
			out_last_q  <= (cnt_q == CW'(1));
			out_empty_q <= 1'b0;
		end else if (empty_load) begin
			out_valid_q <= 1'b1;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.character = out_char_q;
	assign out_ch.last      = out_last_q;
	assign out_ch.empty_res = out_empty_q;

endmodule

// ===== rtl/core/itoa_checker.sv =====
module itoa_checker
	import itoa_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input char_t out_char,
	input logic  out_last,
	input logic  out_empty
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
		&& $stable(out_last) && $stable(out_empty))
		else $error("stalled output changed");

	// one conversion at a time: busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while converting");

	// an empty result is a lone, blank, final transfer
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> out_last && (out_char == CHAR_NONE))
		else $error("malformed empty result");

	// every real character is a digit, a lowercase hex letter or a minus
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_empty |->
		((out_char >= CHAR_ZERO) && (out_char <= CHAR_ZERO + 7'd9))
		|| ((out_char >= CHAR_ALPHA) && (out_char <= CHAR_ALPHA + 7'd5))
		|| (out_char == CHAR_MINUS))
		else $error("character outside digit set");

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.character),
	.out_last  (out_ch.last),
	.out_empty (out_ch.empty_res)
);

// ===== test/itoa_result_check.sv =====
`timescale 1ns / 100ps

// Watches both channels of the radix converter. Each accepted input
// transfer is expanded into the character stream it must produce. Each
// output transfer is checked against the oldest character still owed.
module itoa_result_check
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	itoa_in_if   in_ch,
	itoa_out_if  out_ch,
	output int   errors,
	output int   pending
);

	typedef struct {
		char_t character;
		logic  last;
		logic  empty_res;
	} char_rec_t;

	char_rec_t expected_chars[$];
	int        mismatches = 0;

	assign errors = mismatches;

	// Expand one conversion into the characters it owes, most significant first
	task automatic queue_conversion(input logic [VALUE_WIDTH-1:0] word, input base_t radix,
			input logic sgn);
		char_rec_t              rec;
		char_t                  text[$];
		char_t                  c;
		logic [VALUE_WIDTH-1:0] mag;
		logic                   minus;
		digit_t                 d;
		if (radix < BASE_MIN || radix > BASE_MAX) begin
			rec.character = CHAR_NONE;
			rec.last      = 1'b1;
			rec.empty_res = 1'b1;
			expected_chars.push_back(rec);
		end else begin
			// only base ten honors the sign; the most negative word wraps to itself,
			// which read as unsigned is the right magnitude
			minus = sgn && radix == BASE_SIGNED && word[VALUE_WIDTH-1];
			mag   = minus ? -word : word;
			// a zero word still yields one digit
			do begin
				d = digit_t'(mag % VALUE_WIDTH'(radix));
				if (d < 4'd10) c = CHAR_ZERO + char_t'(d);
				else c = CHAR_ALPHA + char_t'(d - 4'd10);
				text.push_front(c);
				mag = mag / VALUE_WIDTH'(radix);
			end while (mag != 0);
			if (minus) text.push_front(CHAR_MINUS);
			foreach (text[i]) begin
				rec.character = text[i];
				rec.last      = (i == text.size() - 1);
				rec.empty_res = 1'b0;
				expected_chars.push_back(rec);
			end
		end
	endtask

	// Predict on input transfers first, then retire output transfers
	always @(posedge clk or negedge arst_n) begin
		char_rec_t want;
		if (!arst_n) begin
			expected_chars.delete();
			pending <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				queue_conversion(in_ch.value, in_ch.base, in_ch.signed_mode);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected transfer char=%h last=%b empty=%b", $realtime,
							out_ch.character, out_ch.last, out_ch.empty_res);
				end else begin
					want = expected_chars.pop_front();
					if (out_ch.character !== want.character || out_ch.last !== want.last ||
							out_ch.empty_res !== want.empty_res) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp char=%h last=%b empty=%b, got char=%h last=%b empty=%b",
								$realtime, want.character, want.last, want.empty_res,
								out_ch.character, out_ch.last, out_ch.empty_res);
					end
				end
			end
			pending <= expected_chars.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import itoa_pkg::*;

	localparam int VALUE_WIDTH = 32;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   errors;
	int   pending;

	itoa_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_ch ();
	itoa_out_if out_ch ();

	integer_to_ascii_radix #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.STORE_DEPTH(34)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	itoa_result_check #(.VALUE_WIDTH(VALUE_WIDTH)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.errors(errors),
		.pending(pending)
	);

	always #4 clk = ~clk;

	// receiver backpressure, off during the calm stretch
	always @(posedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 15);
	end

	// one input transfer, with an optional idle gap in front of it
	task automatic send_item(input logic [VALUE_WIDTH-1:0] word, input base_t radix,
			input logic sgn);
		int gap;
		gap = 0;
		if (!calm) while ($urandom_range(99) < 15) gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.value       <= word;
		in_ch.base        <= radix;
		in_ch.signed_mode <= sgn;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// hold the input until every owed character has come out
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [VALUE_WIDTH-1:0] word;
		base_t                  radix;
		int                     pick;
		in_ch.valid       <= 1'b0;
		in_ch.value       <= '0;
		in_ch.base        <= '0;
		in_ch.signed_mode <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, extremes, sign handling, every digit, bad radix
		send_item('0, BASE_SIGNED, 1'b0);
		send_item('0, BASE_SIGNED, 1'b1);
		send_item('0, BASE_MIN, 1'b0);
		send_item('1, BASE_MIN, 1'b0);
		send_item(32'h8000_0000, BASE_SIGNED, 1'b1);
		send_item(32'h8000_0000, BASE_SIGNED, 1'b0);
		send_item('1, BASE_SIGNED, 1'b1);
		send_item('1, BASE_SIGNED, 1'b0);
		send_item(32'h7fff_ffff, BASE_SIGNED, 1'b1);
		send_item('1, BASE_MAX, 1'b1);
		send_item(32'hdead_beef, BASE_MAX, 1'b0);
		send_item(32'h0123_4567, BASE_MAX, 1'b0);
		send_item(32'h89ab_cdef, BASE_MAX, 1'b1);
		send_item('1, 5'd3, 1'b0);
		send_item(32'h8000_0000, 5'd8, 1'b1);
		send_item(32'd1, BASE_MIN, 1'b1);
		send_item(32'd9, BASE_SIGNED, 1'b0);
		send_item(32'd16, BASE_MAX, 1'b0);
		send_item(32'd224, 5'd15, 1'b1);
		send_item($urandom, 5'd0, 1'b0);
		send_item('1, 5'd1, 1'b1);
		send_item($urandom, 5'd17, 1'b1);
		send_item('1, 5'd31, 1'b0);
		drain();

		// random: mostly valid radixes, base ten favored, values of many magnitudes
		for (int n = 0; n < 370; n++) begin
			calm = (n >= 150 && n < 210);
			if (n == 100 || n == 300) drain();
			pick = $urandom_range(0, 5);
			case (pick)
				0: word = $urandom;
				1: word = $urandom_range(0, 255);
				2: word = $urandom_range(0, 99999);
				3: begin
					case ($urandom_range(0, 2))
						0: word = 32'h8000_0000 + $urandom_range(0, 3);
						1: word = 32'h7fff_ffff - $urandom_range(0, 3);
						default: word = '1 - $urandom_range(0, 3);
					endcase
				end
				default: word = $urandom >> $urandom_range(0, 31);
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				radix = base_t'($urandom_range(0, 16));
				if (radix >= BASE_MIN) radix = radix + 5'd15;
			end else if (pick < 40) begin
				radix = BASE_SIGNED;
			end else begin
				radix = base_t'($urandom_range(BASE_MIN, BASE_MAX));
			end
			send_item(word, radix, 1'($urandom_range(0, 1)));
		end
		calm = 1'b0;
		drain();
		repeat (40) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/itoa_pkg.sv
rtl/core/itoa_if.sv
rtl/core/integer_to_ascii_radix.sv
rtl/core/itoa_checker.sv
test/itoa_result_check.sv
test/tb.sv
